FILE: rtl/core/rcsc_pkg.sv
// ----------------------------------------------------------------------------
// rcsc_pkg
// Types, constants and rounding helper shared by the color space converter.
// ----------------------------------------------------------------------------
package rcsc_pkg;

    // conversion select
    typedef enum logic {
        MODE_YCBCR = 1'b0,
        MODE_YCOCG = 1'b1
    } t_mode;

    // register indexes on the configuration port
    localparam logic CFG_IDX_MODE       = 1'b0;
    localparam logic CFG_IDX_MAX_SAMPLE = 1'b1;

    localparam int COMP_W   = 16;   // input component and luma width
    localparam int CHROMA_W = 18;   // chroma field width
    localparam int COEF_W   = 18;
    localparam int SUM_W    = 35;   // 17 x 18 products summed three times
    localparam int FRAC_BITS = 16;

    localparam logic [15:0] MAX_SAMPLE_RST = 16'd255;
    localparam logic [15:0] OFFSET_RST     = 16'd128;

    // coefficients scaled by 65536
    localparam logic signed [COEF_W-1:0] COEF_Y_R  = 18'sd19595;
    localparam logic signed [COEF_W-1:0] COEF_Y_G  = 18'sd38470;
    localparam logic signed [COEF_W-1:0] COEF_Y_B  = 18'sd7471;
    localparam logic signed [COEF_W-1:0] COEF_CB_R = -18'sd11059;
    localparam logic signed [COEF_W-1:0] COEF_CB_G = -18'sd21709;
    localparam logic signed [COEF_W-1:0] COEF_CB_B = 18'sd32768;
    localparam logic signed [COEF_W-1:0] COEF_CR_R = 18'sd32768;
    localparam logic signed [COEF_W-1:0] COEF_CR_G = -18'sd27439;
    localparam logic signed [COEF_W-1:0] COEF_CR_B = -18'sd5329;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] offset;
    } t_cfg;

    // divide by 2^16, rounding half away from zero
    function automatic logic signed [16:0] round_q16(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] q;
        mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        q   = (mag + SUM_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return s[SUM_W-1] ? -$signed(q[16:0]) : $signed(q[16:0]);
    endfunction

endpackage

FILE: rtl/core/rcsc_pix_if.sv
// ----------------------------------------------------------------------------
// rcsc_pix_if
// Stream of RGB pixels with valid / ready handshake.
// ----------------------------------------------------------------------------
interface rcsc_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: rtl/core/rcsc_res_if.sv
// ----------------------------------------------------------------------------
// rcsc_res_if
// Stream of converted pixels with valid / ready handshake.
// ----------------------------------------------------------------------------
interface rcsc_res_if;
    logic               valid;
    logic               ready;
    logic        [15:0] luma;
    logic signed [17:0] chroma_a;
    logic signed [17:0] chroma_b;

    modport source (output valid, output luma, output chroma_a, output chroma_b,
                    input ready);
    modport sink   (input valid, input luma, input chroma_a, input chroma_b,
                    output ready);
endinterface

FILE: rtl/core/rcsc_cfg.sv
// ----------------------------------------------------------------------------
// rcsc_cfg
// Configuration registers: mode and chroma offset derived from max_sample.
// ----------------------------------------------------------------------------
module rcsc_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [15:0]      i_cfg_data,
    output rcsc_pkg::t_cfg   o_cfg
);

    rcsc_pkg::t_mode r_mode;
    logic [15:0]     r_offset;
    logic [15:0]     n_offset;

    // (max_sample + 1) / 2
    assign n_offset = 16'((17'(i_cfg_data) + 17'd1) >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= rcsc_pkg::MODE_YCBCR;
            r_offset <= rcsc_pkg::OFFSET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rcsc_pkg::CFG_IDX_MODE: begin
                    r_mode <= rcsc_pkg::t_mode'(i_cfg_data[0]);
                end
                rcsc_pkg::CFG_IDX_MAX_SAMPLE: begin
                    r_offset <= n_offset;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.mode   = r_mode;
    assign o_cfg.offset = r_offset;

endmodule

FILE: rtl/core/rcsc_convert.sv
// ----------------------------------------------------------------------------
// rcsc_convert
// Combinational datapath: BT.601 YCbCr or YCoCg-R for one pixel.
// ----------------------------------------------------------------------------
module rcsc_convert (
    input  logic        [15:0] i_red,
    input  logic        [15:0] i_green,
    input  logic        [15:0] i_blue,
    input  rcsc_pkg::t_cfg     i_cfg,
    output logic        [15:0] o_luma,
    output logic signed [17:0] o_chroma_a,
    output logic signed [17:0] o_chroma_b
);

    localparam int SW = rcsc_pkg::SUM_W;

    logic signed [16:0] red_s, green_s, blue_s;
    logic signed [SW-1:0] sum_y, sum_cb, sum_cr;
    logic signed [16:0] y_601, cb_601, cr_601;
    logic signed [17:0] co, lift_t, cg, y_lift;
    logic signed [17:0] offset_s;

    assign red_s   = $signed({1'b0, i_red});
    assign green_s = $signed({1'b0, i_green});
    assign blue_s  = $signed({1'b0, i_blue});

    // BT.601 full range
    assign sum_y  = SW'(red_s)   * SW'(rcsc_pkg::COEF_Y_R)
                  + SW'(green_s) * SW'(rcsc_pkg::COEF_Y_G)
                  + SW'(blue_s)  * SW'(rcsc_pkg::COEF_Y_B);
    assign sum_cb = SW'(red_s)   * SW'(rcsc_pkg::COEF_CB_R)
                  + SW'(green_s) * SW'(rcsc_pkg::COEF_CB_G)
                  + SW'(blue_s)  * SW'(rcsc_pkg::COEF_CB_B);
    assign sum_cr = SW'(red_s)   * SW'(rcsc_pkg::COEF_CR_R)
                  + SW'(green_s) * SW'(rcsc_pkg::COEF_CR_G)
                  + SW'(blue_s)  * SW'(rcsc_pkg::COEF_CR_B);

    assign y_601  = rcsc_pkg::round_q16(sum_y);
    assign cb_601 = rcsc_pkg::round_q16(sum_cb);
    assign cr_601 = rcsc_pkg::round_q16(sum_cr);

    // reversible lifting, floor halving
    assign co     = 18'(red_s) - 18'(blue_s);
    assign lift_t = 18'(blue_s) + (co >>> 1);
    assign cg     = 18'(green_s) - lift_t;
    assign y_lift = lift_t + (cg >>> 1);

    assign offset_s = $signed({2'b00, i_cfg.offset});

    always_comb begin
        case (i_cfg.mode)
            rcsc_pkg::MODE_YCOCG: begin
                o_luma     = y_lift[15:0];
                o_chroma_a = co + offset_s;
                o_chroma_b = cg + offset_s;
            end
            default: begin
                o_luma     = y_601[15:0];
                o_chroma_a = 18'(cb_601) + offset_s;
                o_chroma_b = 18'(cr_601) + offset_s;
            end
        endcase
    end

endmodule

FILE: rtl/core/rgb_color_space_converter_top.sv
// a pixel beat accepted into the input register moves on into the result register once that one may load
// one pixel beat per cycle while the sink holds ready; both the input and result registers advance together
// the rate is set by the single multiply-add-round pass between the two registers
// reset: synchronous active low; clears both valid flags, mode to YCbCr, chroma offset to 128 (max_sample 255)
// configuration is taken at any write-enabled edge and applies to input-register pixels still in flight
// ----------------------------------------------------------------------------
// rgb_color_space_converter_top
// RGB to BT.601 YCbCr or YCoCg-R converter, one pixel per clock while the result sink is ready.
// ----------------------------------------------------------------------------
module rgb_color_space_converter_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rcsc_pix_if.sink     i_pix,
    rcsc_res_if.source   o_res,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);

    // components are cut to their low SAMPLE_BITS bits
    localparam logic [15:0] SMASK = 16'((17'd1 << SAMPLE_BITS) - 17'd1);

    rcsc_pkg::t_cfg cfg;

    // input register
    logic        r_in_vld;
    logic [15:0] r_red, r_green, r_blue;

    // result register
    logic               r_out_vld;
    logic        [15:0] r_luma;
    logic signed [17:0] r_chroma_a, r_chroma_b;

    logic               n_out_vld;
    logic               n_in_vld;
    logic               adv_out;   // result register may load
    logic               take_in;   // input beat accepted
    logic        [15:0] luma_c;
    logic signed [17:0] chroma_a_c, chroma_b_c;

    rcsc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rcsc_convert u_convert (
        .i_red      (r_red),
        .i_green    (r_green),
        .i_blue     (r_blue),
        .i_cfg      (cfg),
        .o_luma     (luma_c),
        .o_chroma_a (chroma_a_c),
        .o_chroma_b (chroma_b_c)
    );

    // result register frees when empty or when the sink takes its beat
    assign adv_out     = !r_out_vld || o_res.ready;
    // input register frees when empty or when it moves into the result register
    assign i_pix.ready = !r_in_vld || adv_out;
    assign take_in     = i_pix.valid && i_pix.ready;

    always_comb begin
        n_in_vld  = r_in_vld;
        n_out_vld = r_out_vld;
        if (adv_out) begin
            n_out_vld = r_in_vld;
            n_in_vld  = 1'b0;
        end
        if (take_in) begin
            n_in_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_red   <= i_pix.red & SMASK;
            r_green <= i_pix.green & SMASK;
            r_blue  <= i_pix.blue & SMASK;
        end
        if (adv_out && r_in_vld) begin
            r_luma     <= luma_c;
            r_chroma_a <= chroma_a_c;
            r_chroma_b <= chroma_b_c;
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.luma     = r_luma;
    assign o_res.chroma_a = r_chroma_a;
    assign o_res.chroma_b = r_chroma_b;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB color space converter: pixels are pushed
// through a valid/ready driver, every converted beat is checked against a
// bit-exact YCbCr / YCoCg-R predictor, over several mode and offset settings
// and several idle / stall patterns on both sides.
// ----------------------------------------------------------------------------
module tb;

    localparam int SAMPLE_BITS = 16;
    localparam int STALL_LIMIT = 20000;   // cycles without any beat before giving up
    localparam int PHASE_PIXELS = 240;    // random pixels per configuration phase
    localparam int HOLD_CYCLES = 300;     // long receiver hold-off in the pressure phase

    // full-range BT.601 weights, scaled by 2^16
    localparam longint WY_R = 19595;
    localparam longint WY_G = 38470;
    localparam longint WY_B = 7471;
    localparam longint WCB_R = -11059;
    localparam longint WCB_G = -21709;
    localparam longint WCB_B = 32768;
    localparam longint WCR_R = 32768;
    localparam longint WCR_G = -27439;
    localparam longint WCR_B = -5329;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_rgb_pix;

    typedef struct packed {
        logic        [15:0] luma;
        logic signed [17:0] chroma_a;
        logic signed [17:0] chroma_b;
    } t_conv_pix;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // everything the bench drives, known from time zero
    logic        tx_valid = 1'b0;
    t_rgb_pix    tx_pix = '0;
    logic        rx_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = rcsc_pkg::CFG_IDX_MODE;
    logic [15:0] cfg_data = '0;

    rcsc_pix_if pix_if ();
    rcsc_res_if res_if ();

    assign pix_if.valid = tx_valid;
    assign pix_if.red   = tx_pix.red;
    assign pix_if.green = tx_pix.green;
    assign pix_if.blue  = tx_pix.blue;
    assign res_if.ready = rx_ready;

    rgb_color_space_converter_top #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // bench copy of the two registers, as they stand after reset
    rcsc_pkg::t_mode cur_mode = rcsc_pkg::MODE_YCBCR;
    logic [15:0]     cur_max = 16'd255;

    t_rgb_pix  pix_pending[$];    // pixels waiting to be offered
    t_conv_pix conv_expected[$];  // converted pixels the block still owes us

    // idle knobs, percent of cycles
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    logic        hold_rx = 1'b0;
    bit          hold_go = 1'b0;

    int unsigned err_cnt = 0;
    int unsigned pix_beats = 0;
    int unsigned res_beats = 0;
    int unsigned cfg_writes = 0;
    int unsigned idle_run = 0;

    task automatic report_mismatch(input string msg);
        if (err_cnt < 40)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // divide by 2^16, ties away from zero
    function automatic longint div_q16_away(input longint s);
        if (s >= 0)
            return (s + 32768) / 65536;
        return -((-s + 32768) / 65536);
    endfunction

    // what the block must give for one pixel under the current registers
    function automatic t_conv_pix convert_pixel(input t_rgb_pix p);
        longint    smask, r, g, b, ofs, y, ca, cb, co, t, cg;
        t_conv_pix o;
        smask = (64'sd1 <<< SAMPLE_BITS) - 1;
        r = longint'(p.red) & smask;
        g = longint'(p.green) & smask;
        b = longint'(p.blue) & smask;
        ofs = (longint'(cur_max) + 1) / 2;
        if (cur_mode == rcsc_pkg::MODE_YCBCR) begin
            y  = div_q16_away(WY_R * r + WY_G * g + WY_B * b);
            ca = div_q16_away(WCB_R * r + WCB_G * g + WCB_B * b) + ofs;
            cb = div_q16_away(WCR_R * r + WCR_G * g + WCR_B * b) + ofs;
        end else begin
            // lifting steps, halving rounds toward minus infinity
            co = r - b;
            t  = b + (co >>> 1);
            cg = g - t;
            y  = t + (cg >>> 1);
            ca = co + ofs;
            cb = cg + ofs;
        end
        o.luma     = y[15:0];
        o.chroma_a = ca[17:0];
        o.chroma_b = cb[17:0];
        return o;
    endfunction

    // pixel driver: a beat moves at an edge with valid and ready both high
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_valid <= 1'b0;
        end else begin
            if (tx_valid && pix_if.ready) begin
                conv_expected.push_back(convert_pixel(tx_pix));
                pix_beats++;
            end
            // only move on once the current beat is gone
            if (!tx_valid || pix_if.ready) begin
                if (pix_pending.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    tx_pix   <= pix_pending.pop_front();
                    tx_valid <= 1'b1;
                end else begin
                    tx_valid <= 1'b0;
                end
            end
        end
    end

    // result side: random back-pressure, forced low during the hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n)
            rx_ready <= 1'b0;
        else
            rx_ready <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);
    end

    // monitor: check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_conv_pix want;
        if (i_rst_n && res_if.valid && rx_ready) begin
            res_beats++;
            if (conv_expected.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing pending: %h %h %h",
                                          res_if.luma, res_if.chroma_a, res_if.chroma_b));
            end else begin
                want = conv_expected.pop_front();
                if (res_if.luma !== want.luma)
                    report_mismatch($sformatf("beat %0d luma %h, want %h",
                                              res_beats, res_if.luma, want.luma));
                if (res_if.chroma_a !== want.chroma_a)
                    report_mismatch($sformatf("beat %0d chroma_a %h, want %h",
                                              res_beats, res_if.chroma_a, want.chroma_a));
                if (res_if.chroma_b !== want.chroma_b)
                    report_mismatch($sformatf("beat %0d chroma_b %h, want %h",
                                              res_beats, res_if.chroma_b, want.chroma_b));
            end
        end
    end

    // watchdog: too long with no beat on either side means a hang
    always @(posedge i_clk) begin
        if ((tx_valid && pix_if.ready) || (res_if.valid && rx_ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("rgb_color_space_converter_top test failed");
            $finish;
        end
    end

    // long receiver hold-off, timed here so the sender keeps offering pixels
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // register write; mirrors the value into the bench copy at the write edge
    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == rcsc_pkg::CFG_IDX_MODE)
            cur_mode = rcsc_pkg::t_mode'(data[0]);  // upper data bits do not belong to mode
        else
            cur_max = data;
        cfg_writes++;
    endtask

    // wait until every pixel is out and every result is back, then let the
    // two-stage pipe settle before touching registers
    task automatic drain();
        while (pix_pending.size() != 0 || tx_valid || conv_expected.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // component picker, weighted toward the corners and the current max_sample
    function automatic logic [15:0] pick_comp();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return cur_max;
            3:       return cur_max + 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    t_rgb_pix corner_pix[12] = '{
        '{16'h0000, 16'h0000, 16'h0000},   // black
        '{16'hFFFF, 16'hFFFF, 16'hFFFF},   // full white
        '{16'hFFFF, 16'h0000, 16'h0000},   // pure primaries, then yellow
        '{16'h0000, 16'hFFFF, 16'h0000},
        '{16'h0000, 16'h0000, 16'hFFFF},
        '{16'hFFFF, 16'hFFFF, 16'h0000},
        '{16'hAAAA, 16'h5555, 16'hAAAA},   // alternating bit patterns
        '{16'h5555, 16'hAAAA, 16'h5555},
        '{16'h0001, 16'h0000, 16'h0000},   // chroma lands exactly on a half
        '{16'h0000, 16'h0000, 16'h0001},
        '{16'h00FF, 16'h00FF, 16'h00FF},   // at max_sample
        '{16'h03E8, 16'h0002, 16'h9C40}    // well above max_sample, no clamping
    };

    // main sequence
    initial begin
        logic [15:0]     phase_max;
        rcsc_pkg::t_mode phase_mode;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: corners in YCbCr with reset registers, then in YCoCg-R
        foreach (corner_pix[k])
            pix_pending.push_back(corner_pix[k]);
        drain();
        write_reg(rcsc_pkg::CFG_IDX_MODE, 16'hFFFF);   // mode bit set, junk above it
        foreach (corner_pix[k])
            pix_pending.push_back(corner_pix[k]);
        drain();

        // random phases, each with its own mode, offset and idle pattern
        for (int p = 0; p < 8; p++) begin
            phase_mode = rcsc_pkg::t_mode'(p[0] ^ p[2]);
            case (p)
                0, 4:    phase_max = 16'd0;       // zero offset
                1, 5:    phase_max = 16'd1;
                2, 3:    phase_max = 16'hFFFF;    // largest offset
                default: phase_max = 16'($urandom);
            endcase
            write_reg(rcsc_pkg::CFG_IDX_MODE, {15'($urandom), phase_mode});
            write_reg(rcsc_pkg::CFG_IDX_MAX_SAMPLE, phase_max);

            case (p % 4)
                0: begin
                    tx_idle_pct  <= 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_idle_pct  <= 47;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct  <= 0;
                    rx_stall_pct <= 47;
                end
                default: begin
                    tx_idle_pct  <= 29;
                    rx_stall_pct <= 29;
                end
            endcase
            // one phase gets the long hold-off, with the sender never idle
            if (p == 2)
                hold_go = 1'b1;

            for (int n = 0; n < PHASE_PIXELS; n++)
                pix_pending.push_back('{pick_comp(), pick_comp(), pick_comp()});
            drain();
        end

        repeat (8) @(posedge i_clk);
        $display("covered %0d pixel beats and %0d result beats over %0d register writes,",
                 pix_beats, res_beats, cfg_writes);
        $display("both modes, offsets from zero to the top, with idle, stall and hold-off");
        if (err_cnt == 0) begin
            $display("rgb_color_space_converter_top test passed");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("rgb_color_space_converter_top test failed");
        end
        $finish;
    end

endmodule
